/* rtl/tdrf_pkg.sv */
// shared types and constants for the tree deepest roots finder
// no dependencies
package tdrf_pkg;

    localparam int VALUE_W     = 7;
    localparam int CFG_W       = 7;
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic
    {
        ACT_ADD_EDGE = 1'b0,
        ACT_COMPUTE  = 1'b1
    } action_t;

endpackage

/* rtl/tdrf_ram.sv */
// generic single write port ram with registered read
// no dependencies
module tdrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/tree_deepest_roots_finder.sv */
// Deepest roots finder for an undirected graph of up to MAX_NODES nodes.
// An edge transaction with both nodes in range is a read-modify-write of two rows of the
// adjacency ram: row a is read and written, then row b. A compute transaction counts
// components by flooding, then runs two depth-first walks if there is only one component
// and otherwise sends an error result. The flood and the walks each test one adjacency
// bit per cycle while scanning a row. Each node takes one full row scan in the flood and
// one in each walk. In each walk a node's row is scanned again up to its first unvisited
// neighbor whenever one of its children is pushed. The results are then counted and sent,
// and sending waits while the output is not taken.
// The input is not ready while a transaction is in progress. The configuration port is
// ready only when the block is idle and no result is waiting.
// Depends on tdrf_pkg and tdrf_ram.
module tree_deepest_roots_finder
    import tdrf_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data,     // num_nodes
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,      // node_a, node_b, zero pad
    input  logic                   s_tuser,      // action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,      // value, zero pad
    output logic                   m_tuser,      // is_error
    output logic                   m_tlast
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int EXT_W = ((CW > VALUE_W) ? CW : VALUE_W) + 1;
    localparam logic [MAX_NODES-1:0] ONE_BIT = MAX_NODES'(1);
    localparam logic [CW-1:0]        MAXC    = CW'(MAX_NODES);

    typedef enum logic [4:0]
    {
        S_IDLE, S_E_RA, S_E_WA, S_E_RB, S_E_WB,
        S_F_START, S_F_POP, S_F_W1, S_F_W2, S_F_W3, S_F_LOAD, S_F_SCAN,
        S_ERR, S_D_INIT, S_D_W, S_D_LOAD, S_D_SCAN, S_D_T1, S_D_T2,
        S_R_SCAN, S_T_SCAN, S_EMIT, S_FIN
    } state_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       num_nodes_reg;
    logic [MAX_NODES-1:0]   row_valid_reg;
    logic                   adj_vld_reg;
    logic [MAX_NODES-1:0]   row_reg;
    logic [MAX_NODES-1:0]   visited_reg;
    logic [MAX_NODES-1:0]   mask_reg;
    logic [MAX_NODES-1:0]   set1_reg;
    logic [NW-1:0]          row_idx_reg;
    logic [NW-1:0]          stk_raddr_reg;
    logic [NW-1:0]          a_idx_reg;
    logic [NW-1:0]          b_idx_reg;
    logic [NW-1:0]          root_reg;
    logic [NW-1:0]          top_reg;
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          start_reg;
    logic [CW-1:0]          head_reg;
    logic [CW-1:0]          tail_reg;
    logic [CW-1:0]          comps_reg;
    logic [CW-1:0]          sp_reg;
    logic [CW-1:0]          best_reg;
    logic                   pass_reg;
    logic [RES_W-1:0]       total_reg;
    logic [RES_W-1:0]       emitted_reg;
    logic                   m_tvalid_reg;
    logic [VALUE_W-1:0]     m_value_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;

    logic [MAX_NODES-1:0]   adj_rdata;
    logic [MAX_NODES-1:0]   adj_eff;
    logic                   adj_we;
    logic [NW-1:0]          adj_waddr;
    logic [MAX_NODES-1:0]   adj_wdata;
    logic [NW-1:0]          stk_rdata;
    logic                   stk_we;
    logic [NW-1:0]          stk_waddr;
    logic [NW-1:0]          stk_wdata;

    logic [VALUE_W-1:0]     in_a;
    logic [VALUE_W-1:0]     in_b;
    logic                   edge_ok;
    logic [EXT_W-1:0]       num_ext;
    logic [CW-1:0]          n_cur;
    logic [NW-1:0]          cur_i;
    logic                   i_end;
    logic                   row_bit;
    logic                   vis_bit;
    logic                   f_seed;
    logic                   f_take;
    logic                   d_take;
    logic                   out_free;
    logic                   err_load;
    logic                   emit_done;
    logic                   emit_load;
    logic [CW-1:0]          best_rec;
    logic [MAX_NODES-1:0]   mask_rec;

    tdrf_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (row_idx_reg),
        .rdata (adj_rdata)
    );

    tdrf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr_reg),
        .rdata (stk_rdata)
    );

    assign in_a    = s_tdata[VALUE_W-1:0];
    assign in_b    = s_tdata[2*VALUE_W-1:VALUE_W];
    assign edge_ok = (in_a != '0) && (EXT_W'(in_a) <= EXT_W'(MAX_NODES))
                  && (in_b != '0) && (EXT_W'(in_b) <= EXT_W'(MAX_NODES));
    assign num_ext = EXT_W'(num_nodes_reg);

    always_comb
    begin
        if (num_ext == '0)
        begin
            n_cur = CW'(1);
        end
        else if (num_ext > EXT_W'(MAX_NODES))
        begin
            n_cur = MAXC;
        end
        else
        begin
            n_cur = CW'(num_ext);
        end
    end

    assign cur_i   = i_reg[NW-1:0];
    assign i_end   = (i_reg == n_cur);
    assign row_bit = row_reg[cur_i];
    assign vis_bit = visited_reg[cur_i];
    assign adj_eff = adj_vld_reg ? adj_rdata : '0;

    assign f_seed = (state_reg == S_F_START) && (start_reg != n_cur)
                 && !visited_reg[start_reg[NW-1:0]];
    assign f_take = (state_reg == S_F_SCAN) && !i_end && row_bit && !vis_bit
                 && (tail_reg < MAXC);
    assign d_take = (state_reg == S_D_SCAN) && !i_end && row_bit && !vis_bit
                 && (sp_reg < MAXC);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign err_load  = (state_reg == S_ERR) && out_free;
    assign emit_done = i_end || (emitted_reg == total_reg);
    assign emit_load = (state_reg == S_EMIT) && !emit_done && set1_reg[cur_i] && out_free;

    // running deepest set of the current walk
    always_comb
    begin
        best_rec = best_reg;
        mask_rec = mask_reg;
        if (sp_reg > best_reg)
        begin
            best_rec = sp_reg;
            mask_rec = ONE_BIT << top_reg;
        end
        else if (sp_reg == best_reg)
        begin
            mask_rec = mask_reg | (ONE_BIT << top_reg);
        end
    end

    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = a_idx_reg;
        adj_wdata = adj_eff | (ONE_BIT << b_idx_reg);
        if (state_reg == S_E_WA)
        begin
            adj_we = 1'b1;
        end
        else if (state_reg == S_E_WB)
        begin
            adj_we    = 1'b1;
            adj_waddr = b_idx_reg;
            adj_wdata = adj_eff | (ONE_BIT << a_idx_reg);
        end
    end

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = cur_i;
        if (state_reg == S_D_INIT)
        begin
            stk_we    = 1'b1;
            stk_wdata = root_reg;
        end
        else if (f_seed)
        begin
            stk_we    = 1'b1;
            stk_wdata = start_reg[NW-1:0];
        end
        else if (f_take)
        begin
            stk_we    = 1'b1;
            stk_waddr = tail_reg[NW-1:0];
        end
        else if (d_take)
        begin
            stk_we    = 1'b1;
            stk_waddr = sp_reg[NW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_nodes_reg <= CFG_W'(1);
            row_valid_reg <= '0;
            adj_vld_reg   <= 1'b0;
            row_reg       <= '0;
            visited_reg   <= '0;
            mask_reg      <= '0;
            set1_reg      <= '0;
            row_idx_reg   <= '0;
            stk_raddr_reg <= '0;
            a_idx_reg     <= '0;
            b_idx_reg     <= '0;
            root_reg      <= '0;
            top_reg       <= '0;
            i_reg         <= '0;
            start_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            comps_reg     <= '0;
            sp_reg        <= '0;
            best_reg      <= '0;
            pass_reg      <= 1'b0;
            total_reg     <= '0;
            emitted_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
            m_value_reg   <= '0;
            m_tuser_reg   <= 1'b0;
            m_tlast_reg   <= 1'b0;
        end
        else
        begin
            adj_vld_reg <= row_valid_reg[row_idx_reg];
            if (cfg_valid && cfg_ready)
            begin
                num_nodes_reg <= cfg_data;
            end
            if (m_tready && !err_load && !emit_load)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser == ACT_COMPUTE)
                        begin
                            visited_reg <= '0;
                            start_reg   <= '0;
                            comps_reg   <= '0;
                            state_reg   <= S_F_START;
                        end
                        else if (edge_ok)
                        begin
                            a_idx_reg   <= NW'(EXT_W'(in_a) - EXT_W'(1));
                            b_idx_reg   <= NW'(EXT_W'(in_b) - EXT_W'(1));
                            row_idx_reg <= NW'(EXT_W'(in_a) - EXT_W'(1));
                            state_reg   <= S_E_RA;
                        end
                    end
                end
                S_E_RA:
                begin
                    state_reg <= S_E_WA;
                end
                S_E_WA:
                begin
                    row_valid_reg[a_idx_reg] <= 1'b1;
                    row_idx_reg              <= b_idx_reg;
                    state_reg                <= S_E_RB;
                end
                S_E_RB:
                begin
                    state_reg <= S_E_WB;
                end
                S_E_WB:
                begin
                    row_valid_reg[b_idx_reg] <= 1'b1;
                    state_reg                <= S_IDLE;
                end
                // breadth-first flood for the component count
                S_F_START:
                begin
                    if (start_reg == n_cur)
                    begin
                        if (comps_reg > CW'(1))
                        begin
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            root_reg  <= '0;
                            pass_reg  <= 1'b0;
                            best_reg  <= '0;
                            mask_reg  <= '0;
                            state_reg <= S_D_INIT;
                        end
                    end
                    else if (f_seed)
                    begin
                        comps_reg                          <= comps_reg + CW'(1);
                        visited_reg[start_reg[NW-1:0]]     <= 1'b1;
                        head_reg                           <= '0;
                        tail_reg                           <= CW'(1);
                        state_reg                          <= S_F_POP;
                    end
                    else
                    begin
                        start_reg <= start_reg + CW'(1);
                    end
                end
                S_F_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        start_reg <= start_reg + CW'(1);
                        state_reg <= S_F_START;
                    end
                    else
                    begin
                        stk_raddr_reg <= head_reg[NW-1:0];
                        head_reg      <= head_reg + CW'(1);
                        state_reg     <= S_F_W1;
                    end
                end
                S_F_W1:
                begin
                    state_reg <= S_F_W2;
                end
                S_F_W2:
                begin
                    row_idx_reg <= stk_rdata;
                    state_reg   <= S_F_W3;
                end
                S_F_W3:
                begin
                    state_reg <= S_F_LOAD;
                end
                S_F_LOAD:
                begin
                    row_reg   <= adj_eff;
                    i_reg     <= '0;
                    state_reg <= S_F_SCAN;
                end
                S_F_SCAN:
                begin
                    if (i_end)
                    begin
                        state_reg <= S_F_POP;
                    end
                    else
                    begin
                        if (f_take)
                        begin
                            visited_reg[cur_i] <= 1'b1;
                            tail_reg           <= tail_reg + CW'(1);
                        end
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_ERR:
                begin
                    if (err_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= 1'b1;
                        m_value_reg  <= VALUE_W'(comps_reg);
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_FIN;
                    end
                end
                // depth-first walk, one neighbor test per cycle while scanning a row
                S_D_INIT:
                begin
                    visited_reg <= ONE_BIT << root_reg;
                    sp_reg      <= CW'(1);
                    top_reg     <= root_reg;
                    row_idx_reg <= root_reg;
                    state_reg   <= S_D_W;
                end
                S_D_W:
                begin
                    state_reg <= S_D_LOAD;
                end
                S_D_LOAD:
                begin
                    row_reg   <= adj_eff;
                    i_reg     <= '0;
                    state_reg <= S_D_SCAN;
                end
                S_D_SCAN:
                begin
                    if (d_take)
                    begin
                        visited_reg[cur_i] <= 1'b1;
                        sp_reg             <= sp_reg + CW'(1);
                        top_reg            <= cur_i;
                        row_idx_reg        <= cur_i;
                        state_reg          <= S_D_W;
                    end
                    else if (!i_end)
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                    else
                    begin
                        best_reg <= best_rec;
                        mask_reg <= mask_rec;
                        sp_reg   <= sp_reg - CW'(1);
                        i_reg    <= '0;
                        if (sp_reg == CW'(1))
                        begin
                            if (!pass_reg)
                            begin
                                set1_reg  <= mask_rec;
                                pass_reg  <= 1'b1;
                                state_reg <= S_R_SCAN;
                            end
                            else
                            begin
                                set1_reg  <= set1_reg | mask_rec;
                                total_reg <= '0;
                                state_reg <= S_T_SCAN;
                            end
                        end
                        else
                        begin
                            stk_raddr_reg <= NW'(sp_reg - CW'(2));
                            state_reg     <= S_D_T1;
                        end
                    end
                end
                S_D_T1:
                begin
                    state_reg <= S_D_T2;
                end
                S_D_T2:
                begin
                    top_reg     <= stk_rdata;
                    row_idx_reg <= stk_rdata;
                    state_reg   <= S_D_W;
                end
                S_R_SCAN:
                begin
                    if (i_end)
                    begin
                        root_reg  <= '0;
                        state_reg <= S_D_INIT;
                    end
                    else if (set1_reg[cur_i])
                    begin
                        root_reg  <= cur_i;
                        state_reg <= S_D_INIT;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_T_SCAN:
                begin
                    if (i_end)
                    begin
                        i_reg       <= '0;
                        emitted_reg <= '0;
                        state_reg   <= S_EMIT;
                    end
                    else
                    begin
                        if (set1_reg[cur_i] && (total_reg != RES_W'(MAX_RESULTS)))
                        begin
                            total_reg <= total_reg + RES_W'(1);
                        end
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_EMIT:
                begin
                    if (emit_done)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (!set1_reg[cur_i])
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                    else if (emit_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= 1'b0;
                        m_value_reg  <= VALUE_W'(i_reg + CW'(1));
                        m_tlast_reg  <= (emitted_reg + RES_W'(1) == total_reg);
                        emitted_reg  <= emitted_reg + RES_W'(1);
                        i_reg        <= i_reg + CW'(1);
                    end
                end
                S_FIN:
                begin
                    row_valid_reg <= '0;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_TDATA_W'(m_value_reg);
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= MAXC || state_reg == S_IDLE || state_reg == S_F_START)
        else $error("walk stack pointer beyond node count");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error transaction without last");
    a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (row_valid_reg == '0))
        else $error("adjacency not cleared after compute");
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emitted_reg <= total_reg))
        else $error("more results than counted");
`endif

endmodule
